[design/sbd_pkg.sv]
`timescale 1ns / 1ps
// sbd_pkg: shared types and constants for the soft-bit depuncturer.
// No dependencies.

package sbd_pkg;

	localparam int SOFT_W   = 8;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int PERIOD_W = 6;
	localparam int DELAY_W  = 5;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 2'd2;

	localparam logic [SOFT_W-1:0] ERASURE = 8'd127;

	// output tuser bit positions
	localparam int TU_ERASURE = 0;
	localparam int TU_PEND    = 1;
	localparam int TUSER_W    = 2;

	typedef struct packed {
		logic busy;
		logic all_zero;
	} cfg_stat_t;

endpackage

[design/soft_bit_depuncturer.sv]
`timescale 1ns / 1ps
// Soft-bit depuncturer top level: input queue, configuration unit, output sequencer.
// Input bytes are registered in the queue, results in the output register. The
// output sequencer emits one period position per cycle while a byte is queued,
// the output register is free and no setup sweep runs; an input leaves the queue
// after the erasures before it, its byte and any trailing erasures. Reset: pattern 1,
// period 1, delay 0, position 0. A register write starts a result-free setup sweep.

module soft_bit_depuncturer #(
	parameter int MAX_PERIOD = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sbd_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sbd_pkg::SOFT_W-1:0]     s_tdata,   // [7:0] soft_in
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sbd_pkg::SOFT_W-1:0]     m_tdata,   // [7:0] soft_out
	output logic [sbd_pkg::TUSER_W-1:0]    m_tuser,   // [0] is_erasure, [1] period_end
	output logic                           m_tlast
);

	localparam int EffMax = (MAX_PERIOD < 32) ? MAX_PERIOD : 32;
	localparam int PW     = $clog2(EffMax + 1);
	localparam int PosW   = $clog2(EffMax);

	logic [EffMax-1:0]          pattern;
	logic [PW-1:0]              period_eff;
	logic [PosW-1:0]            start_q0;
	logic [PosW-1:0]            last_kept;
	sbd_pkg::cfg_stat_t         stat;
	logic                       full;
	logic                       nempty;
	logic                       pop;
	logic [sbd_pkg::SOFT_W-1:0] head;
	logic                       push;

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	sbd_cfg #(
		.MAX_PERIOD(MAX_PERIOD)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pattern   (pattern),
		.period_eff(period_eff),
		.start_q0  (start_q0),
		.last_kept (last_kept),
		.stat      (stat)
	);

	sbd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(s_tdata),
		.full     (full),
		.pop      (pop),
		.nempty   (nempty),
		.head     (head)
	);

	sbd_back #(
		.MAX_PERIOD(MAX_PERIOD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pattern   (pattern),
		.period_eff(period_eff),
		.start_q0  (start_q0),
		.last_kept (last_kept),
		.stat      (stat),
		.nempty    (nempty),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

[design/sbd_cfg.sv]
`timescale 1ns / 1ps
// sbd_cfg: configuration registers and the setup sweep that finds the rotated
// start offset and the last kept position. Depends on sbd_pkg.

module sbd_cfg #(
	parameter int MAX_PERIOD = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [sbd_pkg::CFG_W-1:0]      cfg_wdata,
	output logic [((MAX_PERIOD < 32) ? MAX_PERIOD : 32)-1:0] pattern,
	output logic [$clog2(((MAX_PERIOD < 32) ? MAX_PERIOD : 32) + 1)-1:0] period_eff,
	output logic [$clog2((MAX_PERIOD < 32) ? MAX_PERIOD : 32)-1:0] start_q0,
	output logic [$clog2((MAX_PERIOD < 32) ? MAX_PERIOD : 32)-1:0] last_kept,
	output sbd_pkg::cfg_stat_t             stat
);

	localparam int EffMax = (MAX_PERIOD < 32) ? MAX_PERIOD : 32;
	localparam int PW     = $clog2(EffMax + 1);
	localparam int PosW   = $clog2(EffMax);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROT  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;

	logic [1:0]                     state_q;
	logic [EffMax-1:0]              pattern_q;
	logic [PW-1:0]                  p_q;
	logic [sbd_pkg::DELAY_W-1:0]    delay_q;
	logic [sbd_pkg::DELAY_W-1:0]    dcnt_q;
	logic [PosW-1:0]                q0_q;
	logic [PosW-1:0]                spos_q;
	logic [PosW-1:0]                sq_q;
	logic [PosW-1:0]                last_q;
	logic                           found_q;
	logic                           all_zero_q;

	logic                           wr_ok;
	logic [sbd_pkg::PERIOD_W-1:0]   wp;
	logic [PW-1:0]                  p_new;
	logic [PW-1:0]                  p_last;
	logic [PW-1:0]                  bit_idx;
	logic                           kept;

	assign wr_ok  = cfg_we && (cfg_idx == sbd_pkg::REG_PATTERN || cfg_idx == sbd_pkg::REG_PERIOD
		|| cfg_idx == sbd_pkg::REG_DELAY);
	assign wp     = cfg_wdata[sbd_pkg::PERIOD_W-1:0];
	assign p_last = p_q - PW'(1);
	assign bit_idx = p_last - PW'(sq_q);
	assign kept   = pattern_q[bit_idx[PosW-1:0]];

	always_comb begin
		if (wp == '0) begin
			p_new = PW'(1);
		end else if ({1'b0, wp} > 7'(EffMax)) begin
			p_new = PW'(EffMax);
		end else begin
			p_new = PW'(wp);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pattern_q  <= EffMax'(1);
			p_q        <= PW'(1);
			delay_q    <= '0;
			dcnt_q     <= '0;
			q0_q       <= '0;
			spos_q     <= '0;
			sq_q       <= '0;
			last_q     <= '0;
			found_q    <= 1'b0;
			all_zero_q <= 1'b0;
		end else if (wr_ok) begin
			state_q <= ST_ROT;
			q0_q    <= '0;
			unique case (cfg_idx)
				sbd_pkg::REG_PATTERN: begin
					pattern_q <= cfg_wdata[EffMax-1:0];
					dcnt_q    <= delay_q;
				end
				sbd_pkg::REG_PERIOD: begin
					p_q    <= p_new;
					dcnt_q <= delay_q;
				end
				default: begin
					delay_q <= cfg_wdata[sbd_pkg::DELAY_W-1:0];
					dcnt_q  <= cfg_wdata[sbd_pkg::DELAY_W-1:0];
				end
			endcase
		end else begin
			unique case (state_q)
				ST_ROT: begin
					// step the start offset back once per delay count, modulo the period
					if (dcnt_q == '0) begin
						state_q <= ST_SCAN;
						spos_q  <= '0;
						sq_q    <= q0_q;
						found_q <= 1'b0;
					end else begin
						dcnt_q <= dcnt_q - 1'b1;
						q0_q   <= (q0_q == '0) ? p_last[PosW-1:0] : q0_q - 1'b1;
					end
				end
				ST_SCAN: begin
					if (kept) begin
						last_q  <= spos_q;
						found_q <= 1'b1;
					end
					if (PW'(spos_q) == p_last) begin
						state_q    <= ST_IDLE;
						all_zero_q <= !(found_q || kept);
					end else begin
						spos_q <= spos_q + 1'b1;
						sq_q   <= (PW'(sq_q) == p_last) ? '0 : sq_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign pattern       = pattern_q;
	assign period_eff    = p_q;
	assign start_q0      = q0_q;
	assign last_kept     = last_q;
	assign stat.busy     = (state_q != ST_IDLE);
	assign stat.all_zero = all_zero_q;

endmodule

[design/sbd_fifo.sv]
`timescale 1ns / 1ps
// sbd_fifo: front side, a two-entry queue of accepted soft bytes.
// Depends on sbd_pkg.

module sbd_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [sbd_pkg::SOFT_W-1:0]  push_data,
	output logic                        full,
	input  logic                        pop,
	output logic                        nempty,
	output logic [sbd_pkg::SOFT_W-1:0]  head
);

	logic [sbd_pkg::SOFT_W-1:0] mem_q [2];
	logic                       wptr_q;
	logic                       rptr_q;
	logic [1:0]                 cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign full   = cnt_q[1];
	assign nempty = (cnt_q != '0);
	assign head   = mem_q[rptr_q];

endmodule

[design/sbd_back.sv]
`timescale 1ns / 1ps
// sbd_back: back side sequencer that, unless stalled, walks the period one
// position per cycle and drives the output register. Depends on sbd_pkg.

module sbd_back #(
	parameter int MAX_PERIOD = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [((MAX_PERIOD < 32) ? MAX_PERIOD : 32)-1:0] pattern,
	input  logic [$clog2(((MAX_PERIOD < 32) ? MAX_PERIOD : 32) + 1)-1:0] period_eff,
	input  logic [$clog2((MAX_PERIOD < 32) ? MAX_PERIOD : 32)-1:0] start_q0,
	input  logic [$clog2((MAX_PERIOD < 32) ? MAX_PERIOD : 32)-1:0] last_kept,
	input  sbd_pkg::cfg_stat_t             stat,
	input  logic                           nempty,
	input  logic [sbd_pkg::SOFT_W-1:0]     head,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sbd_pkg::SOFT_W-1:0]     m_tdata,
	output logic [sbd_pkg::TUSER_W-1:0]    m_tuser,
	output logic                           m_tlast
);

	localparam int EffMax = (MAX_PERIOD < 32) ? MAX_PERIOD : 32;
	localparam int PW     = $clog2(EffMax + 1);
	localparam int PosW   = $clog2(EffMax);

	logic [PosW-1:0]             pos_q;
	logic [PosW-1:0]             q_q;
	logic                        placed_q;
	logic                        vld_q;
	logic [sbd_pkg::SOFT_W-1:0]  data_q;
	logic [sbd_pkg::TUSER_W-1:0] user_q;
	logic                        last_q;

	logic [PW-1:0]               p_last;
	logic [PW-1:0]               bit_idx;
	logic                        kept;
	logic                        pend;
	logic                        emit_byte;
	logic                        done;
	logic                        load;

	assign p_last    = period_eff - PW'(1);
	assign bit_idx   = p_last - PW'(q_q);
	assign kept      = pattern[bit_idx[PosW-1:0]];
	assign pend      = (PW'(pos_q) == p_last);
	assign emit_byte = kept && !placed_q;
	assign done      = emit_byte ? ((pos_q != last_kept) || pend)
		: (pend && (placed_q || stat.all_zero));
	assign load      = nempty && !stat.busy && (!vld_q || m_tready);
	assign pop       = load && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			q_q      <= '0;
			placed_q <= 1'b0;
			vld_q    <= 1'b0;
		end else begin
			if (stat.busy) begin
				pos_q    <= '0;
				q_q      <= start_q0;
				placed_q <= 1'b0;
			end else if (load) begin
				pos_q    <= pend ? '0 : pos_q + 1'b1;
				q_q      <= (PW'(q_q) == p_last) ? '0 : q_q + 1'b1;
				placed_q <= done ? 1'b0 : (placed_q || emit_byte);
			end
			if (load) begin
				vld_q <= 1'b1;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q                      <= emit_byte ? head : sbd_pkg::ERASURE;
			user_q[sbd_pkg::TU_ERASURE] <= !emit_byte;
			user_q[sbd_pkg::TU_PEND]    <= pend;
			last_q                      <= done;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

endmodule
